// ----- rtl/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the source character tokenizer
// Token kinds, event codes, the result record and character class helpers.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned LineBitsDef = 16;
  localparam int unsigned MaxRes      = 3;
  localparam int unsigned LineOutBits = 16;

  // token kinds
  localparam logic [4:0] KindId    = 5'd0;
  localparam logic [4:0] KindInt   = 5'd1;
  localparam logic [4:0] KindStr   = 5'd2;
  localparam logic [4:0] KindAsgn  = 5'd3;
  localparam logic [4:0] KindPlus  = 5'd4;
  localparam logic [4:0] KindMinus = 5'd5;
  localparam logic [4:0] KindStar  = 5'd6;
  localparam logic [4:0] KindSlash = 5'd7;
  localparam logic [4:0] KindLpar  = 5'd8;
  localparam logic [4:0] KindRpar  = 5'd9;
  localparam logic [4:0] KindLbrc  = 5'd10;
  localparam logic [4:0] KindRbrc  = 5'd11;
  localparam logic [4:0] KindComma = 5'd12;
  localparam logic [4:0] KindLt    = 5'd13;
  localparam logic [4:0] KindGt    = 5'd14;
  localparam logic [4:0] KindSemi  = 5'd15;
  localparam logic [4:0] KindEof   = 5'd16;
  localparam logic [4:0] KindErr   = 5'd17;

  // event codes
  localparam logic [1:0] EvPay = 2'd0;
  localparam logic [1:0] EvEnd = 2'd1;
  localparam logic [1:0] EvOne = 2'd2;
  localparam logic [1:0] EvEof = 2'd3;

  // characters of interest
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;

  typedef struct packed {
    logic [4:0]             kind;
    logic [1:0]             ev;
    logic [7:0]             val;
    logic [LineOutBits-1:0] line;
  } sct_res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    case (c)
      ChEq:   single_kind = KindAsgn;
      8'h2B:  single_kind = KindPlus;
      8'h2D:  single_kind = KindMinus;
      8'h2A:  single_kind = KindStar;
      8'h2F:  single_kind = KindSlash;
      8'h28:  single_kind = KindLpar;
      8'h29:  single_kind = KindRpar;
      8'h7B:  single_kind = KindLbrc;
      8'h7D:  single_kind = KindRbrc;
      8'h2C:  single_kind = KindComma;
      ChLt:   single_kind = KindLt;
      ChGt:   single_kind = KindGt;
      ChSemi: single_kind = KindSemi;
      default: single_kind = KindErr;
    endcase
  endfunction

endpackage

// ----- rtl/sct_in_reg.sv -----
// ----------------------------------------------------------------------------
// sct_in_reg: input holding register
// Captures one source character and its end flag until the scanner takes it.
// ----------------------------------------------------------------------------
module sct_in_reg
  import sct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_i,
  input  logic       eos_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       eos_o
);

  logic       vld_q;
  logic [7:0] char_q;
  logic       eos_q;

  assign ready_o = !vld_q || take_i;
  assign valid_o = vld_q;
  assign char_o  = char_q;
  assign eos_o   = eos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      char_q <= char_i;
      eos_q  <= eos_i;
    end
  end

endmodule

// ----- rtl/sct_scan.sv -----
// ----------------------------------------------------------------------------
// sct_scan: scanner state and per-character decode
// Holds scan mode and line counter; produces up to three results a character.
// ----------------------------------------------------------------------------
module sct_scan
  import sct_pkg::*;
#(
  parameter int unsigned LINE_BITS = LineBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  input  logic       eos_i,
  output sct_res_t   res_o [MaxRes],
  output logic [1:0] count_o
);

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeId   = 2'd1,
    ModeNum  = 2'd2,
    ModeStr  = 2'd3
  } mode_e;

  localparam logic [LINE_BITS-1:0] LineMax = '1;
  localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);

  mode_e                mode_q, mode_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  function automatic logic [LineOutBits-1:0] line_out(input logic [LINE_BITS-1:0] l);
    logic [LINE_BITS+LineOutBits-1:0] ext;
    ext = {{LineOutBits{1'b0}}, l};
    line_out = ext[LineOutBits-1:0];
  endfunction

  always_comb begin
    mode_e                mode_a;
    logic                 run_idle;
    logic [LINE_BITS-1:0] line_b;
    logic [1:0]           n;
    logic [4:0]           open_kind;

    for (int i = 0; i < MaxRes; i++) begin
      res_o[i] = '0;
    end
    n        = 2'd0;
    mode_a   = mode_q;
    run_idle = 1'b0;
    line_b   = line_q;
    open_kind = KindStr;

    // continue or close the open token
    case (mode_q)
      ModeStr: begin
        if (char_i == ChQuote) begin
          res_o[0] = '{KindStr, EvEnd, 8'd0, line_out(line_q)};
          mode_a   = ModeIdle;
        end else begin
          res_o[0] = '{KindStr, EvPay, char_i, line_out(line_q)};
        end
        n = 2'd1;
      end
      ModeId: begin
        if (is_alpha(char_i) || is_digit(char_i) || char_i == ChUnder) begin
          res_o[0] = '{KindId, EvPay, char_i, line_out(line_q)};
        end else begin
          res_o[0] = '{KindId, EvEnd, 8'd0, line_out(line_q)};
          mode_a   = ModeIdle;
          run_idle = 1'b1;
        end
        n = 2'd1;
      end
      ModeNum: begin
        if (is_digit(char_i)) begin
          res_o[0] = '{KindInt, EvPay, char_i, line_out(line_q)};
        end else begin
          res_o[0] = '{KindInt, EvEnd, 8'd0, line_out(line_q)};
          mode_a   = ModeIdle;
          run_idle = 1'b1;
        end
        n = 2'd1;
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // treat the character as one seen between tokens
    if (run_idle) begin
      if (is_alpha(char_i)) begin
        mode_a   = ModeId;
        res_o[n] = '{KindId, EvPay, char_i, line_out(line_q)};
        n        = n + 2'd1;
      end else if (is_digit(char_i)) begin
        mode_a   = ModeNum;
        res_o[n] = '{KindInt, EvPay, char_i, line_out(line_q)};
        n        = n + 2'd1;
      end else if (char_i == ChQuote) begin
        mode_a = ModeStr;
      end else if (char_i == ChSpace || char_i == ChTab) begin
        mode_a = ModeIdle;
      end else if (char_i == ChNl) begin
        if (line_q != LineMax) begin
          line_b = line_q + LineOne;
        end
      end else begin
        res_o[n] = '{single_kind(char_i), EvOne, char_i, line_out(line_q)};
        n        = n + 2'd1;
      end
    end

    mode_d = mode_a;
    line_d = line_b;

    // close an open token if under two results are already set, and append the end-of-source marker
    if (eos_i) begin
      case (mode_a)
        ModeId:  open_kind = KindId;
        ModeNum: open_kind = KindInt;
        default: open_kind = KindStr;
      endcase
      if (mode_a != ModeIdle && n < 2'd2) begin
        res_o[n] = '{open_kind, EvEnd, 8'd0, line_out(line_b)};
        n        = n + 2'd1;
      end
      res_o[n] = '{KindEof, EvEof, 8'd0, line_out(line_b)};
      n        = n + 2'd1;
      mode_d   = ModeIdle;
      line_d   = LineOne;
    end

    count_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      line_q <= LineOne;
    end else if (take_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
    end
  end

endmodule

// ----- rtl/sct_res_queue.sv -----
// ----------------------------------------------------------------------------
// sct_res_queue: result register bank
// Holds the results of one character and hands them out one per transaction.
// ----------------------------------------------------------------------------
module sct_res_queue
  import sct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  sct_res_t   res_i [MaxRes],
  input  logic [1:0] count_i,
  output logic       free_o,
  output logic       valid_o,
  input  logic       ready_i,
  output sct_res_t   res_o,
  output logic       last_o
);

  sct_res_t   res_q [MaxRes];
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign last_o  = (idx_q == cnt_q - 2'd1);
  assign pop     = valid_o && ready_i;
  assign free_o  = !valid_o || (pop && last_o);
  assign res_o   = res_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= count_i;
      idx_q <= 2'd0;
    end else if (pop && last_o) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MaxRes; i++) begin
        res_q[i] <= res_i[i];
      end
    end
  end

endmodule

// ----- rtl/source_char_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// source_char_tokenizer_unit: streaming source character tokenizer
// Turns a byte stream of source text into identifier, number, string,
// punctuator, error and end-of-source token events.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                  | tlast
//  --------+-----+----------------------------------------+--------------------
//  s_axis  | in  | [7:0] char_byte                        | end_of_source
//  m_axis  | out | [4:0] kind [6:5] event [14:7] value    | last_of_run
//          |     | [30:15] line_number, [31] zero         |
//
//  A character is taken into the input register, decoded combinationally into
//  zero to three results that are loaded into the result bank, and the bank
//  then drains one result per cycle while m_axis_tready is high. With a single
//  result port, a character waits in the input register until the bank is free.
//  The next character is decoded in the same cycle that the last result of
//  the previous one leaves. Reset puts the scanner between tokens on line 1.
//  A stall on m_axis holds the bank and, once the input register is full,
//  drops s_axis_tready.
// ----------------------------------------------------------------------------
module source_char_tokenizer_unit
  import sct_pkg::*;
#(
  parameter int unsigned LINE_BITS = LineBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [4:0] token_kind, [6:5] event_res,
                                      // [14:7] value_byte, [30:15] line_number
  output logic        m_axis_tlast    // last_of_run
);

  logic       in_vld;
  logic [7:0] in_char;
  logic       in_eos;
  logic       take;
  logic       q_free;
  sct_res_t   scan_res [MaxRes];
  logic [1:0] scan_cnt;
  sct_res_t   out_res;

  // decode the held character once the result bank can take its results
  assign take = in_vld && q_free;

  sct_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .char_i  (s_axis_tdata),
    .eos_i   (s_axis_tlast),
    .take_i  (take),
    .valid_o (in_vld),
    .char_o  (in_char),
    .eos_o   (in_eos)
  );

  sct_scan #(
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .char_i  (in_char),
    .eos_i   (in_eos),
    .res_o   (scan_res),
    .count_o (scan_cnt)
  );

  sct_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .res_i   (scan_res),
    .count_i (scan_cnt),
    .free_o  (q_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res),
    .last_o  (m_axis_tlast)
  );

  // pack the result fields, lowest field first, pad to a whole word
  assign m_axis_tdata = {1'b0, out_res.line, out_res.val, out_res.ev, out_res.kind};

endmodule
